@@ design/pts_pkg.sv @@
// ----------------------------------------------------------------------------
// Periodic priority task scheduler package
// Shared widths, codes, state encoding and the result record.
// ----------------------------------------------------------------------------
package pts_pkg;

	localparam int NUM_TASKS_DEF   = 8;
	localparam int PERIOD_BITS_DEF = 16;

	localparam int PRIO_W      = 8;
	localparam int IN_PERIOD_W = 16;
	localparam int TASK_OUT_W  = 3;
	localparam int TICK_W      = 32;

	localparam logic [PRIO_W-1:0] NO_PRIORITY = 8'hFF;

	typedef enum logic [1:0] {
		MODE_SUSPENDED = 2'd0,
		MODE_READY     = 2'd1
	} mode_t;

	typedef enum logic [1:0] {
		OP_TICK      = 2'd0,
		OP_CREATE    = 2'd1,
		OP_ACTIVATE  = 2'd2,
		OP_TERMINATE = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CREATE,
		ST_READ,
		ST_MODIFY,
		ST_SCAN,
		ST_FIX_OLD,
		ST_FIX_NEW,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic                  status;
		logic                  disp_valid;
		logic [TASK_OUT_W-1:0] disp_task;
		logic                  cur_valid;
		logic [TASK_OUT_W-1:0] cur_task;
		logic [TICK_W-1:0]     tick_count;
	} result_t;

endpackage

@@ design/pts_ram.sv @@
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module pts_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 8
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

@@ design/pts_ctrl.sv @@
// ----------------------------------------------------------------------------
// Scheduler sequencer
// Decodes requests, walks the task table in RAM one entry per cycle on a
// tick, tracks the best ready task and writes back the mode changes.
// ----------------------------------------------------------------------------
module pts_ctrl #(
	parameter int NUM_TASKS   = pts_pkg::NUM_TASKS_DEF,
	parameter int PERIOD_BITS = pts_pkg::PERIOD_BITS_DEF
) (
	input  logic                                       clk,
	input  logic                                       arst_n,
	input  logic                                       start,
	input  logic [1:0]                                 operation,
	input  logic [7:0]                                 task_index,
	input  logic [pts_pkg::PRIO_W-1:0]                 task_priority,
	input  logic [pts_pkg::IN_PERIOD_W-1:0]            task_period,
	input  logic                                       cfg_running,
	output logic                                       busy,
	output logic                                       done,
	output pts_pkg::result_t                           result,
	output logic                                       ram_we,
	output logic [$clog2(NUM_TASKS)-1:0]               ram_waddr,
	output logic [pts_pkg::PRIO_W+2*PERIOD_BITS+1:0]   ram_wdata,
	output logic [$clog2(NUM_TASKS)-1:0]               ram_raddr,
	input  logic [pts_pkg::PRIO_W+2*PERIOD_BITS+1:0]   ram_rdata
);

	import pts_pkg::*;

	localparam int IDX_W = $clog2(NUM_TASKS);

	typedef struct packed {
		logic [PRIO_W-1:0]      prio;
		logic [PERIOD_BITS-1:0] period;
		logic [PERIOD_BITS-1:0] timer;
		mode_t                  mode;
	} entry_t;

	function automatic logic [TASK_OUT_W-1:0] out_idx(input logic [IDX_W-1:0] idx);
		logic [IDX_W+TASK_OUT_W-1:0] wide;
		wide = {{TASK_OUT_W{1'b0}}, idx};
		return wide[TASK_OUT_W-1:0];
	endfunction

	function automatic mode_t idle_mode(input logic [PERIOD_BITS-1:0] period);
		return (period != '0) ? MODE_SUSPENDED : MODE_READY;
	endfunction

	state_t state_q, state_d;

	op_t                    op_q;
	logic [IDX_W-1:0]       idx_q;
	logic [PRIO_W-1:0]      prio_q;
	logic [PERIOD_BITS-1:0] period_q;
	logic [NUM_TASKS-1:0]   created_q;
	logic                   run_present_q;
	logic [IDX_W-1:0]       run_idx_q;
	logic [TICK_W-1:0]      tick_q;
	logic                   status_q;
	logic                   disp_valid_q;
	logic [IDX_W-1:0]       disp_task_q;
	logic [IDX_W:0]         rd_idx_q;
	logic                   proc_valid_s1;
	logic [IDX_W-1:0]       proc_idx_s1;
	logic                   found_q;
	logic [IDX_W-1:0]       best_idx_q;
	logic [PRIO_W-1:0]      best_prio_q;
	entry_t                 best_word_q;
	entry_t                 run_word_q;

	logic                          accept;
	logic                          acc_status;
	logic                          idx_ok;
	logic [IDX_W-1:0]              in_idx;
	logic [PERIOD_BITS+IN_PERIOD_W-1:0] period_wide;
	logic [PERIOD_BITS-1:0]        period_in;
	logic                          scan_end;
	logic                          beat;
	logic                          cand;
	entry_t                        ent_rd;
	entry_t                        ent_upd;
	entry_t                        wr_word;

	assign idx_ok      = task_index < 8'(NUM_TASKS);
	assign in_idx      = task_index[IDX_W-1:0];
	assign period_wide = {{PERIOD_BITS{1'b0}}, task_period};
	assign period_in   = period_wide[PERIOD_BITS-1:0];
	assign scan_end    = rd_idx_q == (IDX_W+1)'(NUM_TASKS);
	assign beat        = found_q && run_present_q && (best_prio_q < run_word_q.prio);

	// Per-entry tick update of the word just read.
	always_comb begin
		ent_rd  = entry_t'(ram_rdata);
		ent_upd = ent_rd;
		if (created_q[proc_idx_s1] && ent_rd.period != '0) begin
			if (ent_rd.timer == '0) begin
				if (ent_rd.mode == MODE_SUSPENDED) begin
					ent_upd.mode = MODE_READY;
				end
				ent_upd.timer = ent_rd.period;
			end else begin
				ent_upd.timer = ent_rd.timer - PERIOD_BITS'(1);
			end
		end
		cand = proc_valid_s1 && created_q[proc_idx_s1] && (ent_upd.mode == MODE_READY) &&
			(ent_upd.prio < best_prio_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		accept     = 1'b0;
		acc_status = 1'b0;
		ram_we     = 1'b0;
		ram_waddr  = idx_q;
		ram_raddr  = idx_q;
		wr_word    = ent_upd;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					accept = 1'b1;
					case (op_t'(operation))
						OP_TICK: begin
							state_d = cfg_running ? ST_SCAN : ST_DONE;
						end
						OP_CREATE: begin
							acc_status = !(idx_ok && !created_q[in_idx]);
							state_d    = acc_status ? ST_DONE : ST_CREATE;
						end
						OP_ACTIVATE: begin
							acc_status = !(idx_ok && created_q[in_idx]);
							state_d    = acc_status ? ST_DONE : ST_READ;
						end
						OP_TERMINATE: begin
							state_d = run_present_q ? ST_READ : ST_DONE;
						end
						default: begin
							state_d = ST_DONE;
						end
					endcase
				end
			end
			ST_CREATE: begin
				ram_we  = 1'b1;
				wr_word = '{prio: prio_q, period: period_q, timer: period_q,
					mode: MODE_SUSPENDED};
				state_d = ST_DONE;
			end
			ST_READ: begin
				state_d = ST_MODIFY;
			end
			ST_MODIFY: begin
				ram_we       = 1'b1;
				wr_word      = ent_rd;
				wr_word.mode = (op_q == OP_ACTIVATE) ? MODE_READY : MODE_SUSPENDED;
				state_d      = ST_DONE;
			end
			ST_SCAN: begin
				ram_raddr = rd_idx_q[IDX_W-1:0];
				ram_waddr = proc_idx_s1;
				ram_we    = proc_valid_s1 && created_q[proc_idx_s1];
				if (scan_end && proc_valid_s1) begin
					state_d = ST_FIX_OLD;
				end
			end
			ST_FIX_OLD: begin
				ram_waddr = run_idx_q;
				wr_word   = run_word_q;
				if (beat) begin
					ram_we       = 1'b1;
					wr_word.mode = MODE_READY;
				end else if (!found_q && run_present_q) begin
					ram_we       = 1'b1;
					wr_word.mode = idle_mode(run_word_q.period);
				end
				state_d = found_q ? ST_FIX_NEW : ST_DONE;
			end
			ST_FIX_NEW: begin
				ram_we       = 1'b1;
				ram_waddr    = best_idx_q;
				wr_word      = best_word_q;
				wr_word.mode = idle_mode(best_word_q.period);
				state_d      = ST_DONE;
			end
			ST_DONE: begin
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign ram_wdata = wr_word;
	assign busy      = state_q != ST_IDLE;
	assign done      = state_q == ST_DONE;

	// Control state: table occupancy, current task, tick count, scan pointer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			created_q     <= '0;
			run_present_q <= 1'b0;
			run_idx_q     <= '0;
			tick_q        <= '0;
			rd_idx_q      <= '0;
			proc_valid_s1 <= 1'b0;
			found_q       <= 1'b0;
			status_q      <= 1'b0;
			disp_valid_q  <= 1'b0;
			disp_task_q   <= '0;
		end else begin
			if (accept) begin
				status_q      <= acc_status;
				disp_valid_q  <= 1'b0;
				disp_task_q   <= '0;
				rd_idx_q      <= '0;
				proc_valid_s1 <= 1'b0;
				found_q       <= 1'b0;
				if (op_t'(operation) == OP_TICK && cfg_running) begin
					tick_q <= tick_q + TICK_W'(1);
				end
			end
			if (state_q == ST_SCAN) begin
				if (!scan_end) begin
					rd_idx_q      <= rd_idx_q + (IDX_W+1)'(1);
					proc_valid_s1 <= 1'b1;
				end else begin
					proc_valid_s1 <= 1'b0;
				end
				if (cand) begin
					found_q <= 1'b1;
				end
			end
			if (state_q == ST_CREATE) begin
				created_q[idx_q] <= 1'b1;
			end
			if (state_q == ST_MODIFY && op_q == OP_TERMINATE) begin
				run_present_q <= 1'b0;
				run_idx_q     <= '0;
			end
			if (state_q == ST_FIX_OLD) begin
				disp_valid_q <= found_q || run_present_q;
				disp_task_q  <= found_q ? best_idx_q : run_idx_q;
			end
			if (state_q == ST_FIX_NEW) begin
				run_present_q <= 1'b1;
				run_idx_q     <= best_idx_q;
			end
		end
	end

	// Request payload and scan datapath.
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q        <= op_t'(operation);
			idx_q       <= (op_t'(operation) == OP_TERMINATE) ? run_idx_q : in_idx;
			prio_q      <= task_priority;
			period_q    <= period_in;
			best_prio_q <= NO_PRIORITY;
		end
		if (state_q == ST_SCAN) begin
			proc_idx_s1 <= rd_idx_q[IDX_W-1:0];
			if (cand) begin
				best_idx_q  <= proc_idx_s1;
				best_prio_q <= ent_upd.prio;
				best_word_q <= ent_upd;
			end
			if (proc_valid_s1 && proc_idx_s1 == run_idx_q) begin
				run_word_q <= ent_upd;
			end
		end
	end

	assign result = '{
		status:     status_q,
		disp_valid: disp_valid_q,
		disp_task:  out_idx(disp_task_q),
		cur_valid:  run_present_q,
		cur_task:   run_present_q ? out_idx(run_idx_q) : '0,
		tick_count: tick_q
	};

endmodule

@@ design/periodic_priority_task_scheduler_unit.sv @@
// ----------------------------------------------------------------------------
// Periodic priority task scheduler
// Fixed-priority scheduler over a task table held in RAM.
// ----------------------------------------------------------------------------
//
//   Channel   Handshake                 Payload
//   --------  ------------------------  ----------------------------------------
//   request   start / busy              operation, task_index, task_priority,
//                                       task_period
//   result    done (one-cycle strobe)   status, dispatched_valid, dispatched_task,
//                                       current_valid, current_task, tick_count
//   config    cfg_valid / cfg_ready     cfg_data (scheduler running)
//
// A request is taken when start is high and busy is low; busy then stays high
// until the cycle after the done strobe.
// A create passes through a write state before done; an activate, or a terminate
// with a current task, through a read and a modify state; a rejected request or
// a tick while stopped goes straight to done. A running tick walks the task
// table through the single RAM read port, one entry per cycle, and then writes
// back up to two mode changes. Reset clears the table occupancy flags, the
// current task record and the tick counter at once; the table RAM itself needs
// no clearing. Results cannot be held off by the receiver; done is high for a
// single cycle, and the result fields then hold until the next request is taken.
module periodic_priority_task_scheduler_unit #(
	parameter int NUM_TASKS   = pts_pkg::NUM_TASKS_DEF,
	parameter int PERIOD_BITS = pts_pkg::PERIOD_BITS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	output logic                               busy,
	input  logic [1:0]                         operation,
	input  logic [7:0]                         task_index,
	input  logic [pts_pkg::PRIO_W-1:0]         task_priority,
	input  logic [pts_pkg::IN_PERIOD_W-1:0]    task_period,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic                               cfg_data,
	output logic                               done,
	output logic                               status,
	output logic                               dispatched_valid,
	output logic [pts_pkg::TASK_OUT_W-1:0]     dispatched_task,
	output logic                               current_valid,
	output logic [pts_pkg::TASK_OUT_W-1:0]     current_task,
	output logic [pts_pkg::TICK_W-1:0]         tick_count
);

	import pts_pkg::*;

	localparam int IDX_W   = $clog2(NUM_TASKS);
	localparam int ENTRY_W = PRIO_W + 2 * PERIOD_BITS + 2;

	// The running flag is the only configuration register. Writes are always
	// taken; the user changes it only while no request is in flight.
	logic cfg_running_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_running_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			cfg_running_q <= cfg_data;
		end
	end

	// Task table: priority, period, timer and mode of every task in one word.
	logic               ram_we;
	logic [IDX_W-1:0]   ram_waddr;
	logic [IDX_W-1:0]   ram_raddr;
	logic [ENTRY_W-1:0] ram_wdata;
	logic [ENTRY_W-1:0] ram_rdata;
	result_t            result;

	pts_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (NUM_TASKS)
	) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// The sequencer owns all read-modify-write traffic to the table. Every
	// access of a request completes before the next request is taken, so a
	// read never races a pending write to the same entry.
	pts_ctrl #(
		.NUM_TASKS   (NUM_TASKS),
		.PERIOD_BITS (PERIOD_BITS)
	) u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.operation     (operation),
		.task_index    (task_index),
		.task_priority (task_priority),
		.task_period   (task_period),
		.cfg_running   (cfg_running_q),
		.busy          (busy),
		.done          (done),
		.result        (result),
		.ram_we        (ram_we),
		.ram_waddr     (ram_waddr),
		.ram_wdata     (ram_wdata),
		.ram_raddr     (ram_raddr),
		.ram_rdata     (ram_rdata)
	);

	// Result fields come straight from registers inside the sequencer.
	assign status           = result.status;
	assign dispatched_valid = result.disp_valid;
	assign dispatched_task  = result.disp_task;
	assign current_valid    = result.cur_valid;
	assign current_task     = result.cur_task;
	assign tick_count       = result.tick_count;

endmodule

@@ design/pts_chk.sv @@
// ----------------------------------------------------------------------------
// Scheduler port checker
// Watches the top-level ports of the scheduler over time.
// ----------------------------------------------------------------------------
module pts_chk (
	input logic       clk,
	input logic       arst_n,
	input logic       start,
	input logic       busy,
	input logic       done,
	input logic       status,
	input logic       dispatched_valid,
	input logic [2:0] dispatched_task,
	input logic       current_valid,
	input logic [2:0] current_task
);

	// An accepted request always occupies the block.
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("request accepted but block not busy");

	// The result strobe never repeats back to back.
	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe longer than one cycle");

	// A dispatched task is the task recorded as current.
	a_disp_current: assert property (@(posedge clk) disable iff (!arst_n)
		done && dispatched_valid |-> current_valid && dispatched_task == current_task)
		else $error("dispatched task differs from current task");

	// A rejected request never dispatches.
	a_reject_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		done && status |-> !dispatched_valid)
		else $error("rejected request reported a dispatch");

endmodule

bind periodic_priority_task_scheduler_unit pts_chk u_pts_chk (
	.clk              (clk),
	.arst_n           (arst_n),
	.start            (start),
	.busy             (busy),
	.done             (done),
	.status           (status),
	.dispatched_valid (dispatched_valid),
	.dispatched_task  (dispatched_task),
	.current_valid    (current_valid),
	.current_task     (current_task)
);
